// File: src/upc_pkg.sv
// Shared types, constants and word-sum helpers for the UDP pseudo-header partial sum core.
package upc_pkg;

	localparam int CFG_AW = 6;
	localparam int CFG_DW = 64;
	localparam int LEN_W = 11;
	localparam int BYTE_W = 8;
	localparam int SUM_W = 32;
	localparam int CMP_W = 17;
	localparam int HDR_BYTES = 8;
	localparam logic [7:0] PROTOCOL_RESET = 8'd17;

	typedef enum logic [2:0] {
		REG_IPV6_MODE = 3'd0,
		REG_SRC_HI    = 3'd1,
		REG_SRC_LO    = 3'd2,
		REG_DST_HI    = 3'd3,
		REG_DST_LO    = 3'd4,
		REG_PORT_PAIR = 3'd5,
		REG_PROTOCOL  = 3'd6,
		REG_UDP_CKSUM = 3'd7
	} reg_idx_t;

	typedef enum logic {
		KIND_BEGIN = 1'b0,
		KIND_BYTE  = 1'b1
	} kind_t;

	// Precomputed word sums of the configuration, refreshed every cycle.
	typedef struct packed {
		logic        ipv6;
		logic [17:0] src_hi;
		logic [17:0] src_lo;
		logic [17:0] dst_hi;
		logic [17:0] dst_lo;
		logic [16:0] src_v4;
		logic [16:0] dst_v4;
		logic [17:0] misc;
	} hdr_sum_t;

	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  udp_length;
		logic              has_payload;
		logic [BYTE_W-1:0] payload_byte;
	} item_t;

	function automatic logic [17:0] word_sum4(input logic [63:0] v);
		logic [17:0] s;
		s = 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
		return s;
	endfunction

	function automatic logic [16:0] word_sum2(input logic [31:0] v);
		logic [16:0] s;
		s = 17'(v[31:16]) + 17'(v[15:0]);
		return s;
	endfunction

endpackage

// File: src/upc_cfg.sv
// Configuration register file with APB-style access and registered header word sums.
module upc_cfg import upc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output hdr_sum_t          hdr_sum
);

	logic        ipv6_q;
	logic [63:0] src_hi_q;
	logic [63:0] src_lo_q;
	logic [63:0] dst_hi_q;
	logic [63:0] dst_lo_q;
	logic [31:0] port_pair_q;
	logic [7:0]  protocol_q;
	logic [15:0] cksum_q;
	logic        wr_en;
	reg_idx_t    idx;
	hdr_sum_t    hdr_sum_q;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign idx = reg_idx_t'(paddr[CFG_AW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv6_q      <= 1'b0;
			src_hi_q    <= '0;
			src_lo_q    <= '0;
			dst_hi_q    <= '0;
			dst_lo_q    <= '0;
			port_pair_q <= '0;
			protocol_q  <= PROTOCOL_RESET;
			cksum_q     <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_IPV6_MODE: ipv6_q <= pwdata[0];
				REG_SRC_HI:    src_hi_q <= pwdata;
				REG_SRC_LO:    src_lo_q <= pwdata;
				REG_DST_HI:    dst_hi_q <= pwdata;
				REG_DST_LO:    dst_lo_q <= pwdata;
				REG_PORT_PAIR: port_pair_q <= pwdata[31:0];
				REG_PROTOCOL:  protocol_q <= pwdata[7:0];
				REG_UDP_CKSUM: cksum_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IPV6_MODE: prdata = CFG_DW'(ipv6_q);
			REG_SRC_HI:    prdata = src_hi_q;
			REG_SRC_LO:    prdata = src_lo_q;
			REG_DST_HI:    prdata = dst_hi_q;
			REG_DST_LO:    prdata = dst_lo_q;
			REG_PORT_PAIR: prdata = CFG_DW'(port_pair_q);
			REG_PROTOCOL:  prdata = CFG_DW'(protocol_q);
			REG_UDP_CKSUM: prdata = CFG_DW'(cksum_q);
			default:       prdata = '0;
		endcase
	end

	// The user must change registers only while idle; the block does not enforce it. The registered sums then lag unseen.
	always_ff @(posedge clk) begin
		hdr_sum_q.ipv6   <= ipv6_q;
		hdr_sum_q.src_hi <= word_sum4(src_hi_q);
		hdr_sum_q.src_lo <= word_sum4(src_lo_q);
		hdr_sum_q.dst_hi <= word_sum4(dst_hi_q);
		hdr_sum_q.dst_lo <= word_sum4(dst_lo_q);
		hdr_sum_q.src_v4 <= word_sum2(src_lo_q[31:0]);
		hdr_sum_q.dst_v4 <= word_sum2(dst_lo_q[31:0]);
		hdr_sum_q.misc   <= 18'(protocol_q) + 18'(port_pair_q[31:16]) + 18'(port_pair_q[15:0])
			+ 18'(cksum_q);
	end

	assign hdr_sum = hdr_sum_q;

endmodule

// File: src/upc_acc.sv
// Packet state, byte pairing, accumulator and result register.
module upc_acc import upc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1472
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  item_t            item,
	input  hdr_sum_t         hdr_sum,
	output logic             adv,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [SUM_W-1:0] partial_sum
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	logic [SUM_W-1:0]  acc_q;
	logic [CNT_W-1:0]  left_q;
	logic [BYTE_W-1:0] held_q;
	logic              pend_q;
	logic              open_q;
	logic              out_valid_q;
	logic [SUM_W-1:0]  sum_q;

	logic [19:0]       v6_sum;
	logic [19:0]       addr_sum;
	logic [SUM_W-1:0]  begin_sum;
	logic [CMP_W-1:0]  raw_cnt;
	logic [CMP_W-1:0]  sat_cnt;
	logic [15:0]       byte_word;
	logic [SUM_W-1:0]  byte_sum;
	logic              last_byte;
	logic              do_begin;
	logic              do_byte;

	assign adv = !out_valid_q || !out_stall;

	assign v6_sum = 20'(hdr_sum.src_hi) + 20'(hdr_sum.src_lo) + 20'(hdr_sum.dst_hi)
		+ 20'(hdr_sum.dst_lo);
	assign addr_sum = hdr_sum.ipv6 ? v6_sum : 20'(hdr_sum.src_v4) + 20'(hdr_sum.dst_v4);
	// Length appears once in the pseudo-header and once in the UDP header.
	assign begin_sum = SUM_W'(addr_sum) + SUM_W'(hdr_sum.misc) + SUM_W'({item.udp_length, 1'b0});

	assign raw_cnt = (item.has_payload && item.udp_length > LEN_W'(HDR_BYTES))
		? CMP_W'(item.udp_length - LEN_W'(HDR_BYTES)) : '0;
	assign sat_cnt = (raw_cnt > CMP_W'(MAX_PAYLOAD)) ? CMP_W'(MAX_PAYLOAD) : raw_cnt;

	assign last_byte = (left_q == CNT_W'(1));
	// Second byte of a pair closes the word; a lone final byte is padded low.
	assign byte_word = pend_q ? {held_q, item.payload_byte} : {item.payload_byte, 8'h00};
	assign byte_sum = acc_q + SUM_W'(byte_word);

	assign do_begin = item_valid && adv && (item.kind == KIND_BEGIN);
	assign do_byte  = item_valid && adv && (item.kind == KIND_BYTE) && open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			left_q      <= '0;
			held_q      <= '0;
			pend_q      <= 1'b0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b0;
			end
			if (do_begin) begin
				acc_q  <= begin_sum;
				held_q <= '0;
				pend_q <= 1'b0;
				if (sat_cnt == '0) begin
					open_q      <= 1'b0;
					left_q      <= '0;
					out_valid_q <= 1'b1;
				end else begin
					open_q <= 1'b1;
					left_q <= sat_cnt[CNT_W-1:0];
				end
			end else if (do_byte) begin
				left_q <= left_q - CNT_W'(1);
				if (pend_q || last_byte) begin
					acc_q  <= byte_sum;
					pend_q <= 1'b0;
				end else begin
					held_q <= item.payload_byte;
					pend_q <= 1'b1;
				end
				if (last_byte) begin
					open_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_begin) begin
			sum_q <= begin_sum;
		end else if (do_byte && last_byte) begin
			sum_q <= byte_sum;
		end
	end

	assign out_valid = out_valid_q;
	assign partial_sum = sum_q;

endmodule

// File: src/udp_pseudo_header_partial_sum_core.sv
// Top level of the UDP pseudo-header partial sum core: input register, config and accumulator.
//
//   port group    | direction | handshake          | carries
//   input items   | in        | in_valid/in_stall  | kind, udp_length, has_payload, payload_byte
//   results       | out       | out_valid/out_stall| partial_sum
//   configuration | in/out    | APB (psel/penable) | eight registers at byte address 8*i
//
// One transaction per cycle in unless in_stall is high; results are registered after the input register.
// The input register feeds the update logic into the accumulator and result register.
// Reset clears packet state and the configuration registers (protocol resets to 17); no clearing pass.
// While a result is held by out_stall, at most one more transaction is taken into the input register,
// then in_stall rises until the result is taken.
module udp_pseudo_header_partial_sum_core import upc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1472
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [LEN_W-1:0]  udp_length,
	input  logic              has_payload,
	input  logic [BYTE_W-1:0] payload_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SUM_W-1:0]  partial_sum,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	logic     valid_s1;
	item_t    item_s1;
	logic     adv;
	logic     load;
	hdr_sum_t hdr_sum;

	assign in_stall = valid_s1 && !adv;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.kind         <= kind_t'(kind);
			item_s1.udp_length   <= udp_length;
			item_s1.has_payload  <= has_payload;
			item_s1.payload_byte <= payload_byte;
		end
	end

	upc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.hdr_sum (hdr_sum)
	);

	upc_acc #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item        (item_s1),
		.hdr_sum     (hdr_sum),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.partial_sum (partial_sum)
	);

endmodule

// File: src/upc_checker.sv
// Port-level checks for the UDP pseudo-header partial sum core, bound to the top level.
module upc_checker import upc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [SUM_W-1:0] partial_sum
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_sum_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(partial_sum))
		else $error("result changed while stalled");

	// Input backs up only behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// A fresh result follows an accepted transaction, through the input register and the result register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching transaction");

endmodule

bind udp_pseudo_header_partial_sum_core upc_checker u_upc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.partial_sum (partial_sum)
);

// File: tb/udp_pseudo_header_partial_sum_checker.sv
// Checker for the UDP pseudo-header partial sum core: tracks registers, predicts sums, compares.
`timescale 1ns / 1ps

module udp_pseudo_header_partial_sum_checker import upc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1472
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              kind,
	input  logic [LEN_W-1:0]  udp_length,
	input  logic              has_payload,
	input  logic [BYTE_W-1:0] payload_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [SUM_W-1:0]  partial_sum,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                sums_due,
	output int                sums_checked
);

	logic        cfg_ipv6;
	logic [63:0] cfg_src_hi;
	logic [63:0] cfg_src_lo;
	logic [63:0] cfg_dst_hi;
	logic [63:0] cfg_dst_lo;
	logic [31:0] cfg_ports;
	logic [7:0]  cfg_proto;
	logic [15:0] cfg_cksum;

	logic [SUM_W-1:0]  running_sum;
	int unsigned       bytes_due;
	logic [BYTE_W-1:0] high_byte;
	logic              high_held;
	logic              dgram_open;

	logic [SUM_W-1:0] expected_sums[$];
	int fails;
	int checked;

	function automatic logic [31:0] lane_sum(input logic [63:0] v);
		logic [31:0] s;
		int i;
		s = '0;
		for (i = 0; i < 4; i++)
			s = s + v[16*i +: 16];
		return s;
	endfunction

	function automatic logic [31:0] header_words(input logic [LEN_W-1:0] len);
		logic [31:0] s;
		if (cfg_ipv6) begin
			s = lane_sum(cfg_src_hi) + lane_sum(cfg_src_lo)
				+ lane_sum(cfg_dst_hi) + lane_sum(cfg_dst_lo);
		end else begin
			s = lane_sum({32'h0, cfg_src_lo[31:0]}) + lane_sum({32'h0, cfg_dst_lo[31:0]});
		end
		// length shows up twice: pseudo-header and UDP header
		s = s + cfg_proto + len + len + cfg_ports[31:16] + cfg_ports[15:0] + cfg_cksum;
		return s;
	endfunction

	task automatic take_item(input logic k, input logic [LEN_W-1:0] len, input logic has,
			input logic [BYTE_W-1:0] b);
		int unsigned count;
		if (k == KIND_BEGIN) begin
			running_sum = header_words(len);
			high_byte = '0;
			high_held = 1'b0;
			count = (has && len > HDR_BYTES) ? len - HDR_BYTES : 0;
			if (count > MAX_PAYLOAD)
				count = MAX_PAYLOAD;
			if (count == 0) begin
				dgram_open = 1'b0;
				bytes_due = 0;
				expected_sums.push_back(running_sum);
			end else begin
				dgram_open = 1'b1;
				bytes_due = count;
			end
		end else if (dgram_open) begin
			if (high_held) begin
				running_sum = running_sum + {high_byte, b};
				high_held = 1'b0;
			end else begin
				high_byte = b;
				high_held = 1'b1;
			end
			bytes_due--;
			if (bytes_due == 0) begin
				// odd tail byte gets a zero low half
				if (high_held) begin
					running_sum = running_sum + {high_byte, 8'h00};
					high_held = 1'b0;
				end
				dgram_open = 1'b0;
				expected_sums.push_back(running_sum);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SUM_W-1:0] want;
		if (!arst_n) begin
			cfg_ipv6 = 1'b0;
			cfg_src_hi = '0;
			cfg_src_lo = '0;
			cfg_dst_hi = '0;
			cfg_dst_lo = '0;
			cfg_ports = '0;
			cfg_proto = PROTOCOL_RESET;
			cfg_cksum = '0;
			running_sum = '0;
			bytes_due = 0;
			high_byte = '0;
			high_held = 1'b0;
			dgram_open = 1'b0;
			expected_sums.delete();
			fails = 0;
			checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_sums.size() == 0) begin
					$error("partial_sum %08h arrived with no transaction waiting", partial_sum);
					fails++;
				end else begin
					want = expected_sums.pop_front();
					checked++;
					if (partial_sum !== want) begin
						$error("partial_sum mismatch: expected %08h, actual %08h",
							want, partial_sum);
						fails++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[5:3]))
					REG_IPV6_MODE: cfg_ipv6 = pwdata[0];
					REG_SRC_HI:    cfg_src_hi = pwdata;
					REG_SRC_LO:    cfg_src_lo = pwdata;
					REG_DST_HI:    cfg_dst_hi = pwdata;
					REG_DST_LO:    cfg_dst_lo = pwdata;
					REG_PORT_PAIR: cfg_ports = pwdata[31:0];
					REG_PROTOCOL:  cfg_proto = pwdata[7:0];
					REG_UDP_CKSUM: cfg_cksum = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_item(kind, udp_length, has_payload, payload_byte);
		end
		fail_count <= fails;
		sums_due <= expected_sums.size();
		sums_checked <= checked;
	end

endmodule

// File: tb/tb_udp_pseudo_header_partial_sum_core.sv
// Testbench top for the UDP pseudo-header partial sum core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_udp_pseudo_header_partial_sum_core;
	import upc_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [LEN_W-1:0]  udp_length;
	logic              has_payload;
	logic [BYTE_W-1:0] payload_byte;
	logic              out_valid;
	logic              out_stall;
	logic [SUM_W-1:0]  partial_sum;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	int chk_fails;
	int sums_due;
	int sums_checked;

	int snd_idle_pct;
	int rcv_idle_pct;
	bit long_hold;
	bit line_open;
	int items_sent;
	int datagrams;
	int phase;

	udp_pseudo_header_partial_sum_core #(
		.MAX_PAYLOAD(1472)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.udp_length(udp_length),
		.has_payload(has_payload),
		.payload_byte(payload_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.partial_sum(partial_sum),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	udp_pseudo_header_partial_sum_checker #(
		.MAX_PAYLOAD(1472)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.udp_length(udp_length),
		.has_payload(has_payload),
		.payload_byte(payload_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.partial_sum(partial_sum),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.fail_count(chk_fails),
		.sums_due(sums_due),
		.sums_checked(sums_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$error("run did not finish in time");
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
			end
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] payload_value();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic send_item(input kind_t k, input logic [LEN_W-1:0] len, input logic has,
			input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		udp_length <= len;
		has_payload <= has;
		payload_byte <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_datagram(input logic [LEN_W-1:0] len, input logic has, input int n);
		int i;
		send_item(KIND_BEGIN, len, has, payload_value());
		for (i = 0; i < n; i++)
			send_item(KIND_BYTE, LEN_W'($urandom_range(0, 1480)), 1'($urandom_range(0, 1)),
				payload_value());
		datagrams++;
	endtask

	// stop offering and wait until every predicted sum has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sums_due != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_config(input logic v6, input logic [63:0] sh, input logic [63:0] sl,
			input logic [63:0] dh, input logic [63:0] dl, input logic [31:0] ports,
			input logic [7:0] proto, input logic [15:0] cksum);
		drain();
		// a dropped or open datagram may still be in the pipe
		repeat (4) @(posedge clk);
		write_reg(REG_IPV6_MODE, {63'b0, v6});
		write_reg(REG_SRC_HI, sh);
		write_reg(REG_SRC_LO, sl);
		write_reg(REG_DST_HI, dh);
		write_reg(REG_DST_LO, dl);
		write_reg(REG_PORT_PAIR, {32'b0, ports});
		write_reg(REG_PROTOCOL, {56'b0, proto});
		write_reg(REG_UDP_CKSUM, {48'b0, cksum});
	endtask

	task automatic run_traffic(input int budget);
		int done;
		int r;
		int lr;
		int cnt;
		int n;
		logic [LEN_W-1:0] len;
		logic has;
		done = 0;
		while (done < budget) begin
			r = $urandom_range(99);
			if (r < 8 && !line_open) begin
				// stray bytes with nothing open: ignored, not counted
				repeat ($urandom_range(1, 3))
					send_item(KIND_BYTE, LEN_W'($urandom_range(0, 1480)),
						1'($urandom_range(0, 1)), payload_value());
			end else begin
				lr = $urandom_range(99);
				has = ($urandom_range(9) != 0);
				if (lr < 65) begin
					len = LEN_W'($urandom_range(0, 40));
				end else if (lr < 90) begin
					len = LEN_W'($urandom_range(41, 160));
				end else if (lr < 96) begin
					len = LEN_W'($urandom_range(6, 10));
				end else begin
					len = LEN_W'($urandom_range(161, 1480));
					has = 1'b0;
				end
				cnt = (has && len > HDR_BYTES) ? len - HDR_BYTES : 0;
				n = cnt;
				if (r >= 88 && cnt > 1)
					n = $urandom_range(1, cnt - 1);
				send_datagram(len, has, n);
				line_open = (n < cnt);
				done += 1 + n;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_BEGIN;
		udp_length = '0;
		has_payload = 1'b0;
		payload_byte = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		long_hold = 1'b0;
		line_open = 1'b0;
		items_sent = 0;
		datagrams = 0;
		snd_idle_pct = 21;
		rcv_idle_pct = 63;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners with the registers at their reset values
		send_item(KIND_BEGIN, 11'd0, 1'b0, 8'h5A);
		send_item(KIND_BEGIN, 11'd7, 1'b1, 8'hA5);     // short length, payload flag set
		send_item(KIND_BEGIN, 11'd8, 1'b1, 8'h00);     // header only
		send_item(KIND_BEGIN, 11'd1480, 1'b0, 8'hFF);
		send_item(KIND_BEGIN, 11'd9, 1'b1, 8'h00);     // single odd byte
		send_item(KIND_BYTE, 11'd0, 1'b0, 8'hFF);
		send_item(KIND_BEGIN, 11'd10, 1'b1, 8'h00);
		send_item(KIND_BYTE, 11'd1480, 1'b1, 8'hFF);
		send_item(KIND_BYTE, 11'd0, 1'b0, 8'h00);
		send_item(KIND_BYTE, 11'd1480, 1'b1, 8'hAB);   // stray, nothing open
		send_item(KIND_BEGIN, 11'd12, 1'b1, 8'h00);
		send_item(KIND_BYTE, 11'd3, 1'b0, 8'h12);
		send_item(KIND_BYTE, 11'd4, 1'b1, 8'h34);
		send_item(KIND_BEGIN, 11'd11, 1'b1, 8'h77);    // drops the open datagram
		send_item(KIND_BYTE, 11'd0, 1'b0, 8'h80);
		send_item(KIND_BYTE, 11'd0, 1'b0, 8'h01);
		send_item(KIND_BYTE, 11'd0, 1'b0, 8'hFE);
		send_item(KIND_BEGIN, 11'd8, 1'b0, 8'h3C);
		datagrams += 9;

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_config(1'b0, rand64(), rand64(), rand64(), rand64(), $urandom,
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				1: write_config(1'b1, '1, '1, '1, '1, '1, '1, '1);
				2: write_config(1'b1, rand64(), rand64(), rand64(), rand64(), $urandom,
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				3: write_config(1'b0, '0, '0, '0, '0, '0, '0, '0);
				4: write_config(1'($urandom_range(0, 1)), rand64(), rand64(), rand64(),
					rand64(), $urandom, 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
				default: write_config(1'b0, '1, '1, '1, '1, '1, '1, '1);
			endcase
			if (phase < 2) begin
				snd_idle_pct = 21;
				rcv_idle_pct = 63;
			end else if (phase < 4) begin
				snd_idle_pct = 63;
				rcv_idle_pct = 21;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (phase == 2 || phase == 4) begin
				// header-only datagrams against a held-off result side, back-to-back in phase 4
				long_hold = 1'b1;
				repeat (12) begin
					send_item(KIND_BEGIN, LEN_W'($urandom_range(0, 1480)), 1'b0,
						payload_value());
					datagrams++;
				end
				line_open = 1'b0;
				drain();
			end
			run_traffic(125);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d input transactions in %0d datagrams over 7 register settings,",
			items_sent, datagrams);
		$display("IPv4 and IPv6, with %0d partial sums checked.", sums_checked);
		if (chk_fails == 0 && sums_due == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
